### rtl/core/hash_driven_ternary_sampler_defines.svh
// Assertion helpers for the ternary sampler core.
`ifndef HASH_DRIVEN_TERNARY_SAMPLER_DEFINES_SVH
`define HASH_DRIVEN_TERNARY_SAMPLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HDTS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hdts assertion failed");

// Next-cycle implication, checked outside reset.
`define HDTS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hdts assertion failed");

`endif

### rtl/core/hdts_pkg.sv
package hdts_pkg;

    localparam int POLY_COEFFS = 256;
    localparam int MAX_POLYS   = 64;
    localparam int CW  = $clog2(POLY_COEFFS);
    localparam int PW  = (MAX_POLYS > 1) ? $clog2(MAX_POLYS) : 1;
    localparam int PCW = $clog2(MAX_POLYS + 1) + 1;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Configuration register indexes.
    localparam logic [2:0] CFG_SEED0  = 3'd0;
    localparam logic [2:0] CFG_SEED1  = 3'd1;
    localparam logic [2:0] CFG_SEED2  = 3'd2;
    localparam logic [2:0] CFG_SEED3  = 3'd3;
    localparam logic [2:0] CFG_LEGACY = 3'd4;
    localparam logic [2:0] CFG_MOD    = 3'd5;
    localparam logic [2:0] CFG_PCOUNT = 3'd6;

    localparam logic [7:0] REJECT_LIMIT = 8'd243;

    // Domain separation tags, ASCII bytes, first byte in the top bits.
    localparam logic [215:0] TAG_STRONG =
        216'h4254582D534D494C452D56322D5445524E4152592D5354524F4E47;
    localparam logic [255:0] TAG_LEGACY =
        256'h4254582D534D494C452D56322D5445524E4152592D4C45474143592D53454544;

    localparam logic [255:0] SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    // Head of the restart queue as seen by the back end.
    typedef struct packed {
        logic valid;
        logic restart;
    } t_qhead;

    // Configuration snapshot handed to the back end.
    typedef struct packed {
        logic [255:0] seed;
        logic         legacy;
        logic [31:0]  modulus;
        logic [6:0]   poly_count;
    } t_cfg;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Reverse byte order of a 64-bit word.
    function automatic logic [63:0] bswap64(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 8; i++) begin
            r[63 - 8 * i -: 8] = v[8 * i +: 8];
        end
        return r;
    endfunction

endpackage

### rtl/core/hash_driven_ternary_sampler.sv
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_restart
// output    out        o_valid / i_stall  coefficient, trit, indexes, last
// config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
// A coefficient whose byte comes from the buffer passes through the fetch and emit states, with
// one more fetch per rejected byte; every 32 stream bytes cost two compressions in the single
// iterative SHA-256 round unit.
// A legacy restart adds one more compression before the first block.
// Reset is synchronous and active low; the stream restarts from an all-zero seed.
// The input queue holds four transactions; the output register holds one result.
`include "hash_driven_ternary_sampler_defines.svh"

module hash_driven_ternary_sampler (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_restart,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [31:0]       o_coefficient,
    output logic signed [1:0] o_trit,
    output logic [7:0]        o_coeff_index,
    output logic [5:0]        o_poly_index,
    output logic              o_last,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data
);

    hdts_pkg::t_cfg   r_cfg;
    hdts_pkg::t_qhead head;
    logic             pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seed       <= '0;
            r_cfg.legacy     <= 1'b0;
            r_cfg.modulus    <= 32'd3;
            r_cfg.poly_count <= 7'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hdts_pkg::CFG_SEED0:  r_cfg.seed[255:192] <= i_cfg_data;
                hdts_pkg::CFG_SEED1:  r_cfg.seed[191:128] <= i_cfg_data;
                hdts_pkg::CFG_SEED2:  r_cfg.seed[127:64]  <= i_cfg_data;
                hdts_pkg::CFG_SEED3:  r_cfg.seed[63:0]    <= i_cfg_data;
                hdts_pkg::CFG_LEGACY: r_cfg.legacy        <= i_cfg_data[0];
                hdts_pkg::CFG_MOD:    r_cfg.modulus       <= i_cfg_data[31:0];
                hdts_pkg::CFG_PCOUNT: r_cfg.poly_count    <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    hdts_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_restart (i_restart),
        .i_pop     (pop),
        .o_head    (head)
    );

    hdts_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_head        (head),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_coefficient (o_coefficient),
        .o_trit        (o_trit),
        .o_coeff_index (o_coeff_index),
        .o_poly_index  (o_poly_index),
        .o_last        (o_last)
    );

    // The back end only takes a transaction that is in the queue.
    `HDTS_ASSERT_IMP(a_pop_has_item, pop, head.valid)
    // A zero trit always carries a zero coefficient.
    `HDTS_ASSERT_IMP(a_trit_zero, o_valid && (o_trit == 2'sb00), o_coefficient == 32'd0)
    // The end of the vector falls on the last coefficient of a polynomial.
    `HDTS_ASSERT_IMP(a_last_pos, o_valid && o_last,
        o_coeff_index == 8'(hdts_pkg::POLY_COEFFS - 1))

endmodule

### rtl/core/hdts_sha.sv
module hdts_sha (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [255:0] i_h,
    input  logic [511:0] i_blk,
    output logic         o_done,
    output logic [255:0] o_h
);

    logic [31:0]  r_st [8];
    logic [31:0]  r_w  [16];
    logic [255:0] r_hin;
    logic [5:0]   r_rnd;
    logic         r_busy;
    logic         r_fin;
    logic         r_done;
    logic [255:0] r_hout;

    logic [31:0] t1, t2, w16, s0, s1;

    // One round of the compression function per cycle.
    always_comb begin
        t1 = r_st[7] + (hdts_pkg::rotr(r_st[4], 6) ^ hdts_pkg::rotr(r_st[4], 11)
             ^ hdts_pkg::rotr(r_st[4], 25)) + ((r_st[4] & r_st[5]) ^ (~r_st[4] & r_st[6]))
             + hdts_pkg::SHA_K[r_rnd] + r_w[0];
        t2 = (hdts_pkg::rotr(r_st[0], 2) ^ hdts_pkg::rotr(r_st[0], 13)
             ^ hdts_pkg::rotr(r_st[0], 22))
             + ((r_st[0] & r_st[1]) ^ (r_st[0] & r_st[2]) ^ (r_st[1] & r_st[2]));
        s0 = hdts_pkg::rotr(r_w[1], 7) ^ hdts_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = hdts_pkg::rotr(r_w[14], 17) ^ hdts_pkg::rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w16 = r_w[0] + s0 + r_w[9] + s1;
    end

    // Control: busy over 64 rounds, then the feed-forward add is registered before done rises.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // Working variables and message schedule window.
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_hin <= i_h;
            for (int j = 0; j < 8; j++) begin
                r_st[j] <= i_h[255 - 32 * j -: 32];
            end
            for (int j = 0; j < 16; j++) begin
                r_w[j] <= i_blk[511 - 32 * j -: 32];
            end
        end else if (r_busy) begin
            r_st[0] <= t1 + t2;
            r_st[1] <= r_st[0];
            r_st[2] <= r_st[1];
            r_st[3] <= r_st[2];
            r_st[4] <= r_st[3] + t1;
            r_st[5] <= r_st[4];
            r_st[6] <= r_st[5];
            r_st[7] <= r_st[6];
            for (int j = 0; j < 15; j++) begin
                r_w[j] <= r_w[j + 1];
            end
            r_w[15] <= w16;
        end
        if (r_fin) begin
            for (int j = 0; j < 8; j++) begin
                r_hout[255 - 32 * j -: 32] <= r_hin[255 - 32 * j -: 32] + r_st[j];
            end
        end
    end

    assign o_done = r_done;
    assign o_h    = r_hout;

endmodule

### rtl/core/hdts_front.sv
module hdts_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_restart,
    input  logic             i_pop,
    output hdts_pkg::t_qhead o_head
);

    logic [hdts_pkg::QDEPTH-1:0] r_q;
    logic [hdts_pkg::QAW-1:0]    r_wp, r_rp;
    logic [hdts_pkg::QAW:0]      r_cnt;
    logic                        push, pop;

    assign o_stall = (r_cnt == (hdts_pkg::QAW + 1)'(hdts_pkg::QDEPTH));
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && (r_cnt != '0);

    // Queue of accepted transactions waiting for the back end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_restart;
        end
    end

    assign o_head.valid   = (r_cnt != '0);
    assign o_head.restart = r_q[r_rp];

endmodule

### rtl/core/hdts_back.sv
module hdts_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hdts_pkg::t_cfg   i_cfg,
    input  hdts_pkg::t_qhead i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [31:0]      o_coefficient,
    output logic signed [1:0] o_trit,
    output logic [7:0]       o_coeff_index,
    output logic [5:0]       o_poly_index,
    output logic             o_last
);

    typedef enum logic [5:0] {
        B_IDLE  = 6'b000001,
        B_LEG   = 6'b000010,
        B_FETCH = 6'b000100,
        B_H1    = 6'b001000,
        B_H2    = 6'b010000,
        B_EMIT  = 6'b100000
    } t_bstate;

    t_bstate r_st, n_st;

    logic [63:0]  r_seed [4];
    logic [63:0]  r_ctr;
    logic [255:0] r_buf;
    logic [5:0]   r_off;
    logic [7:0]   r_byte;
    logic [hdts_pkg::CW-1:0] r_coeff;
    logic [hdts_pkg::PW-1:0] r_poly;

    logic         r_ovalid;
    logic [31:0]  r_ocoef;
    logic [1:0]   r_otrit;
    logic [7:0]   r_oci;
    logic [5:0]   r_opi;
    logic         r_olast;

    logic         sha_start, sha_done;
    logic [255:0] sha_hin, sha_hout;
    logic [511:0] sha_blk;

    logic [63:0]  ctr_le;
    logic [511:0] blk_leg, blk1, blk2;
    logic [15:0]  q_prod;
    logic [7:0]   quo, rem;
    logic [hdts_pkg::PCW-1:0] pc;
    logic         coeff_end, poly_end, out_load;

    // Message blocks for the seed expansion and the two stream blocks.
    assign ctr_le  = hdts_pkg::bswap64(r_ctr);
    assign blk_leg = {hdts_pkg::TAG_LEGACY, hdts_pkg::bswap64(i_cfg.seed[255:192]),
                      8'h80, 120'd0, 64'd320};
    assign blk1    = {hdts_pkg::TAG_STRONG, hdts_pkg::bswap64(r_seed[0]),
                      hdts_pkg::bswap64(r_seed[1]), hdts_pkg::bswap64(r_seed[2]),
                      hdts_pkg::bswap64(r_seed[3]), ctr_le[63:24]};
    assign blk2    = {ctr_le[23:0], 8'h80, 416'd0, 64'd536};

    hdts_sha u_sha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sha_start),
        .i_h     (sha_hin),
        .i_blk   (sha_blk),
        .o_done  (sha_done),
        .o_h     (sha_hout)
    );

    // Byte mod 3 by reciprocal multiply.
    assign q_prod = 16'(r_byte) * 16'd171;
    assign quo    = {1'b0, q_prod[15:9]};
    assign rem    = r_byte - 8'(quo * 8'd3);

    // Clamped polynomial count and end-of-vector tests.
    always_comb begin
        if (i_cfg.poly_count == 7'd0) begin
            pc = hdts_pkg::PCW'(1);
        end else if (hdts_pkg::PCW'(i_cfg.poly_count) > hdts_pkg::PCW'(hdts_pkg::MAX_POLYS)) begin
            pc = hdts_pkg::PCW'(hdts_pkg::MAX_POLYS);
        end else begin
            pc = hdts_pkg::PCW'(i_cfg.poly_count);
        end
    end
    assign coeff_end = (r_coeff == hdts_pkg::CW'(hdts_pkg::POLY_COEFFS - 1));
    assign poly_end  = ((hdts_pkg::PCW'(r_poly) + hdts_pkg::PCW'(1)) >= pc);
    assign out_load  = (r_st == B_EMIT) && (!r_ovalid || !i_stall);

    // Sequencer next state and hash requests.
    always_comb begin
        n_st      = r_st;
        o_pop     = 1'b0;
        sha_start = 1'b0;
        sha_hin   = hdts_pkg::SHA_IV;
        sha_blk   = blk1;
        unique case (r_st)
            B_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    if (i_head.restart && i_cfg.legacy) begin
                        sha_start = 1'b1;
                        sha_blk   = blk_leg;
                        n_st      = B_LEG;
                    end else begin
                        n_st = B_FETCH;
                    end
                end
            end
            B_LEG: begin
                sha_blk = blk_leg;
                if (sha_done) begin
                    n_st = B_FETCH;
                end
            end
            B_FETCH: begin
                if (r_off[5]) begin
                    sha_start = 1'b1;
                    n_st      = B_H1;
                end else if (r_buf[255:248] < hdts_pkg::REJECT_LIMIT) begin
                    n_st = B_EMIT;
                end
            end
            B_H1: begin
                if (sha_done) begin
                    sha_start = 1'b1;
                    sha_hin   = sha_hout;
                    sha_blk   = blk2;
                    n_st      = B_H2;
                end
            end
            B_H2: begin
                if (sha_done) begin
                    n_st = B_FETCH;
                end
            end
            B_EMIT: begin
                if (out_load) begin
                    n_st = B_IDLE;
                end
            end
            default: n_st = B_IDLE;
        endcase
    end

    // Stream state, positions and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= B_IDLE;
            for (int i = 0; i < 4; i++) begin
                r_seed[i] <= '0;
            end
            r_ctr    <= '0;
            r_off    <= 6'd32;
            r_coeff  <= '0;
            r_poly   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == B_IDLE && i_head.valid && i_head.restart) begin
                r_ctr   <= '0;
                r_off   <= 6'd32;
                r_coeff <= '0;
                r_poly  <= '0;
                if (!i_cfg.legacy) begin
                    for (int i = 0; i < 4; i++) begin
                        r_seed[i] <= i_cfg.seed[255 - 64 * i -: 64];
                    end
                end
            end
            if (r_st == B_LEG && sha_done) begin
                for (int i = 0; i < 4; i++) begin
                    r_seed[i] <= hdts_pkg::bswap64(sha_hout[255 - 64 * i -: 64]);
                end
            end
            if (r_st == B_FETCH && !r_off[5]) begin
                r_off <= r_off + 6'd1;
            end
            if (r_st == B_H2 && sha_done) begin
                r_off <= '0;
                r_ctr <= r_ctr + 64'd1;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
                if (coeff_end) begin
                    r_coeff <= '0;
                    r_poly  <= poly_end ? '0 : r_poly + 1'b1;
                end else begin
                    r_coeff <= r_coeff + 1'b1;
                end
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Digest byte buffer and output payload.
    always_ff @(posedge i_clk) begin
        if (r_st == B_H2 && sha_done) begin
            r_buf <= sha_hout;
        end else if (r_st == B_FETCH && !r_off[5]) begin
            r_buf  <= {r_buf[247:0], 8'd0};
            r_byte <= r_buf[255:248];
        end
        if (out_load) begin
            case (rem)
                8'd0: begin
                    r_ocoef <= i_cfg.modulus - 32'd1;
                    r_otrit <= 2'b11;
                end
                8'd1: begin
                    r_ocoef <= 32'd0;
                    r_otrit <= 2'b00;
                end
                default: begin
                    r_ocoef <= 32'd1;
                    r_otrit <= 2'b01;
                end
            endcase
            r_oci   <= 8'(r_coeff);
            r_opi   <= 6'(r_poly);
            r_olast <= coeff_end && poly_end;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_coefficient = r_ocoef;
    assign o_trit        = r_otrit;
    assign o_coeff_index = r_oci;
    assign o_poly_index  = r_opi;
    assign o_last        = r_olast;

endmodule
